// ----- src/ctcc_pkg.sv -----
// shared constants, types and helpers for the reduced-width sha-256 tail collision check
// no dependencies; used by the channel interfaces and the top level
package ctcc_pkg;

  // default datapath word width and fixed port field widths
  localparam int WORD_BITS_DEF = 6;
  localparam int FIELD_BITS    = 6;
  localparam int STATE_BITS    = 48;
  localparam int SCHED_BITS    = 42;
  localparam int CFG_DATA_BITS = 48;
  localparam int CFG_IDX_BITS  = 2;

  // seven rounds in the tail, the first four take a candidate word
  localparam int NROUND = 7;
  localparam int NCAND  = 4;

  typedef logic [FIELD_BITS-1:0] field_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FIRST_STATE  = 2'd0,
    REG_SECOND_STATE = 2'd1,
    REG_FIRST_SCHED  = 2'd2,
    REG_SECOND_SCHED = 2'd3
  } reg_idx_t;

  // full 32-bit round constants for rounds 57 to 63
  localparam logic [31:0] K_TAIL [NROUND] = '{
    32'h78a5636f, 32'h84c87814, 32'h8cc70208, 32'h90befffa,
    32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // 32-bit rotate amount scaled to word width w, ties to even, at least 1
  function automatic int scaled(int k32, int w);
    int q;
    int r;
    int rem;
    q   = k32 * w;
    r   = q >> 5;
    rem = q & 31;
    if (rem > 16 || (rem == 16 && (r & 1) == 1)) begin
      r = r + 1;
    end
    if (r < 1) begin
      r = 1;
    end
    return r;
  endfunction

endpackage

// ----- src/ctcc_cand_if.sv -----
// candidate request channel: four first-message words for rounds 57 to 60
// depends on ctcc_pkg for the field type
interface ctcc_cand_if;
  logic              valid;
  logic              ready;
  ctcc_pkg::field_t  cand_word_57;
  ctcc_pkg::field_t  cand_word_58;
  ctcc_pkg::field_t  cand_word_59;
  ctcc_pkg::field_t  cand_word_60;

  modport source (output valid, cand_word_57, cand_word_58, cand_word_59, cand_word_60,
                  input ready);
  modport sink   (input valid, cand_word_57, cand_word_58, cand_word_59, cand_word_60,
                  output ready);
endinterface

// ----- src/ctcc_res_if.sv -----
// result request channel: collision flag and the four derived second-message words
// depends on ctcc_pkg for the field type
interface ctcc_res_if;
  logic              valid;
  logic              ready;
  logic              collided;
  ctcc_pkg::field_t  partner_word_57;
  ctcc_pkg::field_t  partner_word_58;
  ctcc_pkg::field_t  partner_word_59;
  ctcc_pkg::field_t  partner_word_60;

  modport source (output valid, collided, partner_word_57, partner_word_58,
                  partner_word_59, partner_word_60, input ready);
  modport sink   (input valid, collided, partner_word_57, partner_word_58,
                  partner_word_59, partner_word_60, output ready);
endinterface

// ----- src/cascade_tail_collision_check_top.sv -----
// Tail collision checker for SHA-256 rounds 57 to 63 on a WORD_BITS-bit word. Load both
// round-57 states and both sets of earlier schedule words through the cfg port while the
// block is idle, then stream candidates. Each candidate runs through one register stage
// per round (seven) plus a compare/output stage: one request is accepted every cycle unless
// a stalled result has filled every stage, and results leave in the order of acceptance.
// Stages advance independently, so a stalled result still lets bubbles behind it fill.
// depends on ctcc_pkg, ctcc_cand_if and ctcc_res_if
module cascade_tail_collision_check_top #(
  parameter int WORD_BITS = ctcc_pkg::WORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ctcc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [ctcc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  ctcc_cand_if.sink                           cand,
  ctcc_res_if.source                          res
);

  localparam int NROUND = ctcc_pkg::NROUND;
  localparam int NCAND  = ctcc_pkg::NCAND;

  // rotate and shift amounts scaled to the word width
  localparam int RB0_A = ctcc_pkg::scaled(2, WORD_BITS) % WORD_BITS;
  localparam int RB0_B = ctcc_pkg::scaled(13, WORD_BITS) % WORD_BITS;
  localparam int RB0_C = ctcc_pkg::scaled(22, WORD_BITS) % WORD_BITS;
  localparam int RB1_A = ctcc_pkg::scaled(6, WORD_BITS) % WORD_BITS;
  localparam int RB1_B = ctcc_pkg::scaled(11, WORD_BITS) % WORD_BITS;
  localparam int RB1_C = ctcc_pkg::scaled(25, WORD_BITS) % WORD_BITS;
  localparam int RS0_A = ctcc_pkg::scaled(7, WORD_BITS) % WORD_BITS;
  localparam int RS0_B = ctcc_pkg::scaled(18, WORD_BITS) % WORD_BITS;
  localparam int SH_S0 = ctcc_pkg::scaled(3, WORD_BITS);
  localparam int RS1_A = ctcc_pkg::scaled(17, WORD_BITS) % WORD_BITS;
  localparam int RS1_B = ctcc_pkg::scaled(19, WORD_BITS) % WORD_BITS;
  localparam int SH_S1 = ctcc_pkg::scaled(10, WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef word_t [7:0] state_t;

  // per-stage payload: both running states, both word sets, round-61 schedule words
  typedef struct packed {
    state_t           s1;
    state_t           s2;
    word_t [NCAND-1:0] w1;
    word_t [NCAND-1:0] w2;
    word_t            g1;
    word_t            g2;
  } pipe_t;

  // round primitives
  function automatic word_t rotr(word_t x, int k);
    return word_t'((x >> k) | (x << (WORD_BITS - k)));
  endfunction

  function automatic word_t bsig0(word_t a);
    return rotr(a, RB0_A) ^ rotr(a, RB0_B) ^ rotr(a, RB0_C);
  endfunction

  function automatic word_t bsig1(word_t e);
    return rotr(e, RB1_A) ^ rotr(e, RB1_B) ^ rotr(e, RB1_C);
  endfunction

  function automatic word_t ssig0(word_t x);
    return rotr(x, RS0_A) ^ rotr(x, RS0_B) ^ word_t'(x >> SH_S0);
  endfunction

  function automatic word_t ssig1(word_t x);
    return rotr(x, RS1_A) ^ rotr(x, RS1_B) ^ word_t'(x >> SH_S1);
  endfunction

  function automatic word_t t1p(state_t s, word_t k);
    word_t ch;
    ch = (s[4] & s[5]) ^ (~s[4] & s[6]);
    return word_t'(s[7] + bsig1(s[4]) + ch + k);
  endfunction

  function automatic word_t t2p(state_t s);
    word_t mj;
    mj = (s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]);
    return word_t'(bsig0(s[0]) + mj);
  endfunction

  function automatic state_t do_round(state_t s, word_t k, word_t w);
    state_t o;
    word_t  t1;
    t1   = word_t'(t1p(s, k) + w);
    o[7] = s[6];
    o[6] = s[5];
    o[5] = s[4];
    o[4] = word_t'(s[3] + t1);
    o[3] = s[2];
    o[2] = s[1];
    o[1] = s[0];
    o[0] = word_t'(t1 + t2p(s));
    return o;
  endfunction

  function automatic word_t word_at(logic [63:0] p, int i);
    return p[i*WORD_BITS +: WORD_BITS];
  endfunction

  // configuration registers
  logic [ctcc_pkg::STATE_BITS-1:0] first_state;
  logic [ctcc_pkg::STATE_BITS-1:0] second_state;
  logic [ctcc_pkg::SCHED_BITS-1:0] first_sched;
  logic [ctcc_pkg::SCHED_BITS-1:0] second_sched;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_state  <= '0;
      second_state <= '0;
      first_sched  <= '0;
      second_sched <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ctcc_pkg::REG_FIRST_STATE:  first_state  <= ctcc_pkg::STATE_BITS'(cfg_data);
        ctcc_pkg::REG_SECOND_STATE: second_state <= ctcc_pkg::STATE_BITS'(cfg_data);
        ctcc_pkg::REG_FIRST_SCHED:  first_sched  <= ctcc_pkg::SCHED_BITS'(cfg_data);
        ctcc_pkg::REG_SECOND_SCHED: second_sched <= ctcc_pkg::SCHED_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // zero-extended views so words past the packed width read as zero
  logic [63:0] fst_x, sst_x, fsc_x, ssc_x;
  assign fst_x = 64'(first_state);
  assign sst_x = 64'(second_state);
  assign fsc_x = 64'(first_sched);
  assign ssc_x = 64'(second_sched);

  // stage entry payload built from the request and the preloaded states
  pipe_t init_p;
  always_comb begin
    init_p    = '0;
    for (int i = 0; i < 8; i++) begin
      init_p.s1[i] = word_at(fst_x, i);
      init_p.s2[i] = word_at(sst_x, i);
    end
    init_p.w1[0] = word_t'(cand.cand_word_57);
    init_p.w1[1] = word_t'(cand.cand_word_58);
    init_p.w1[2] = word_t'(cand.cand_word_59);
    init_p.w1[3] = word_t'(cand.cand_word_60);
  end

  // round stage registers and per-stage flow control
  pipe_t pipe_q    [NROUND];
  logic  vld       [NROUND];
  logic  stage_rdy [NROUND];
  logic  out_rdy;

  genvar j;
  generate
    for (j = 0; j < NROUND; j++) begin : g_round
      localparam word_t KW = word_t'(ctcc_pkg::K_TAIL[j]);
      pipe_t prev, upd, nxt;
      logic  prev_vld;
      word_t wa, wb;

      // stage input: request port or previous stage
      if (j == 0) begin : g_src_in
        assign prev     = init_p;
        assign prev_vld = cand.valid;
      end else begin : g_src_pipe
        assign prev     = pipe_q[j-1];
        assign prev_vld = vld[j-1];
      end

      // message words for this round
      if (j < NCAND) begin : g_msg
        // partner word cancels the a-register difference
        always_comb begin
          upd       = prev;
          wa        = prev.w1[j];
          wb        = word_t'(wa + t1p(prev.s1, KW) - t1p(prev.s2, KW)
                             + t2p(prev.s1) - t2p(prev.s2));
          upd.w2[j] = wb;
        end
      end else if (j == NCAND) begin : g_sched61
        always_comb begin
          upd    = prev;
          wa     = word_t'(ssig1(prev.w1[2]) + word_at(fsc_x, 4)
                           + ssig0(word_at(fsc_x, 1)) + word_at(fsc_x, 0));
          wb     = word_t'(ssig1(prev.w2[2]) + word_at(ssc_x, 4)
                           + ssig0(word_at(ssc_x, 1)) + word_at(ssc_x, 0));
          upd.g1 = wa;
          upd.g2 = wb;
        end
      end else if (j == NCAND + 1) begin : g_sched62
        always_comb begin
          upd = prev;
          wa  = word_t'(ssig1(prev.w1[3]) + word_at(fsc_x, 5)
                        + ssig0(word_at(fsc_x, 2)) + word_at(fsc_x, 1));
          wb  = word_t'(ssig1(prev.w2[3]) + word_at(ssc_x, 5)
                        + ssig0(word_at(ssc_x, 2)) + word_at(ssc_x, 1));
        end
      end else begin : g_sched63
        always_comb begin
          upd = prev;
          wa  = word_t'(ssig1(prev.g1) + word_at(fsc_x, 6)
                        + ssig0(word_at(fsc_x, 3)) + word_at(fsc_x, 2));
          wb  = word_t'(ssig1(prev.g2) + word_at(ssc_x, 6)
                        + ssig0(word_at(ssc_x, 3)) + word_at(ssc_x, 2));
        end
      end

      // both rounds side by side
      always_comb begin
        nxt    = upd;
        nxt.s1 = do_round(prev.s1, KW, wa);
        nxt.s2 = do_round(prev.s2, KW, wb);
      end

      // a stage takes new data when empty or when its successor takes its data
      if (j == NROUND - 1) begin : g_rdy_last
        assign stage_rdy[j] = !vld[j] || out_rdy;
      end else begin : g_rdy_mid
        assign stage_rdy[j] = !vld[j] || stage_rdy[j+1];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[j] <= 1'b0;
        end else if (stage_rdy[j]) begin
          vld[j] <= prev_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (stage_rdy[j] && prev_vld) begin
          pipe_q[j] <= nxt;
        end
      end
    end
  endgenerate

  assign cand.ready = stage_rdy[0];

  // final compare and output register
  logic                   out_vld;
  logic                   collided;
  ctcc_pkg::field_t [3:0] partner;

  assign out_rdy = !out_vld || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_rdy) begin
      out_vld <= vld[NROUND-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && vld[NROUND-1]) begin
      collided <= (pipe_q[NROUND-1].s1 == pipe_q[NROUND-1].s2);
      for (int i = 0; i < NCAND; i++) begin
        partner[i] <= ctcc_pkg::field_t'(pipe_q[NROUND-1].w2[i]);
      end
    end
  end

  assign res.valid           = out_vld;
  assign res.collided        = collided;
  assign res.partner_word_57 = partner[0];
  assign res.partner_word_58 = partner[1];
  assign res.partner_word_59 = partner[2];
  assign res.partner_word_60 = partner[3];

`ifndef NO_ASSERTIONS
  // an accepted request lands in the first round stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    cand.valid && cand.ready |=> vld[0])
    else $error("accepted request did not enter the first stage");

  // the port only pushes back when every round stage is occupied
  a_full: assert property (@(posedge clk) disable iff (rst)
    !cand.ready |-> vld[0] && vld[1] && vld[2] && vld[3] && vld[4] && vld[5] && vld[6])
    else $error("request refused while a stage was empty");

  // a blocked middle stage keeps its item intact
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !stage_rdy[3] |=> vld[3] && $stable(pipe_q[3]))
    else $error("stalled stage lost or changed its item");

  // a blocked result stays in place
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_vld && !res.ready |=> out_vld && $stable(collided) && $stable(partner))
    else $error("stalled result changed");
`endif

endmodule
